@@ rtl/core/scs_pkg.sv @@
`timescale 1ns / 1ps

package scs_pkg;

  // character codes
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BQUOTE = 8'h60;

  // comment nesting saturates here
  localparam logic [7:0] MAX_NEST = 8'd255;

  // start line after reset
  localparam logic [31:0] START_LINE_RST = 32'd1;

  // lexer mode
  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'b001,
    MODE_COMMENT = 3'b010,
    MODE_QUOTE   = 3'b100
  } lex_mode_t;

endpackage

@@ rtl/core/scs_if.sv @@
`timescale 1ns / 1ps

// input byte channel
interface scs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_text;

  modport source (output valid, output byte_in, output end_of_text, input ready);
  modport sink (input valid, input byte_in, input end_of_text, output ready);
endinterface

// result channel
interface scs_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic        keep;
  logic        chunk_done;
  logic [31:0] line_now;

  modport source (output valid, output byte_out, output keep, output chunk_done,
                  output line_now, input ready);
  modport sink (input valid, input byte_out, input keep, input chunk_done,
                input line_now, output ready);
endinterface

@@ rtl/core/script_chunk_splitter.sv @@
// script_chunk_splitter: splits a script byte stream into chunks.
// in_ch carries one byte per transaction (byte_in, end_of_text); out_ch
// returns exactly one result per input transaction (byte_out, keep,
// chunk_done, line_now). Both channels use valid/ready handshakes.
// cfg_wen/cfg_wdata load the line counter;
// write it only while the block is idle.
// An accepted byte is classified by the lexer state logic and its result
// is in the output register on the next cycle.
// Throughput is one byte per cycle while the receiver takes results; the
// lexer state update is combinational compares and small counters, with no loop between items.
// A new byte is taken while the output register is empty or its result is
// being taken in the same cycle; when the receiver stalls, the result holds
// and in_ch.ready drops until it is taken.
// Reset (rst, synchronous) empties the output register, returns the lexer
// to normal text and loads the line counter with start line 1.
`timescale 1ns / 1ps

module script_chunk_splitter
  import scs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  scs_in_if.sink       in_ch,
  scs_out_if.source    out_ch,
  input  logic         cfg_wen,
  input  logic [31:0]  cfg_wdata
);

  // lexer state
  lex_mode_t   lex_mode, lex_mode_next;
  logic [7:0]  comment_depth, comment_depth_next;
  logic [7:0]  quote_kind, quote_kind_next;
  logic [7:0]  inner_last, inner_last_next;
  logic [7:0]  outer_last, outer_last_next;
  logic        inside_braces, inside_braces_next;
  logic [31:0] line_counter, line_counter_next;

  // output register
  logic        out_valid;
  logic [7:0]  byte_out;
  logic        keep;
  logic        chunk_done;
  logic [7:0]  byte_res;
  logic        keep_res;
  logic        done_res;

  logic        in_accept;
  logic [7:0]  ch;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign ch          = in_ch.byte_in;

  // next lexer state for the incoming byte
  always_comb begin
    lex_mode_next      = lex_mode;
    comment_depth_next = comment_depth;
    quote_kind_next    = quote_kind;
    inner_last_next    = inner_last;
    outer_last_next    = outer_last;
    inside_braces_next = inside_braces;
    line_counter_next  = line_counter;
    keep_res           = 1'b0;
    done_res           = 1'b0;

    if (in_ch.end_of_text) begin
      done_res = 1'b1;
    end else if (ch != CH_CR) begin
      keep_res = 1'b1;
      if (ch == CH_LF) begin
        line_counter_next = line_counter + 32'd1;
      end
      case (lex_mode)
        MODE_COMMENT: begin
          if (inner_last == CH_STAR && ch == CH_SLASH) begin
            if (comment_depth != 8'd0) begin
              comment_depth_next = comment_depth - 8'd1;
            end
          end else if (inner_last == CH_SLASH && ch == CH_STAR) begin
            if (comment_depth < MAX_NEST) begin
              comment_depth_next = comment_depth + 8'd1;
            end
          end
          if (comment_depth_next == 8'd0) begin
            lex_mode_next = MODE_NORMAL;
          end
          inner_last_next = ch;
        end
        MODE_QUOTE: begin
          if (ch == quote_kind && inner_last != CH_BSLASH) begin
            lex_mode_next = MODE_NORMAL;
          end
          inner_last_next = ch;
        end
        default: begin
          if (outer_last == CH_SLASH && ch == CH_STAR) begin
            lex_mode_next      = MODE_COMMENT;
            comment_depth_next = 8'd1;
            inner_last_next    = 8'd0;
          end else if (ch inside {CH_SQUOTE, CH_DQUOTE, CH_BQUOTE}) begin
            lex_mode_next   = MODE_QUOTE;
            quote_kind_next = ch;
            inner_last_next = ch;
          end else if (!inside_braces && outer_last == CH_LF && ch == CH_LF) begin
            done_res = 1'b1;
          end else begin
            if (outer_last == CH_LBRACE) begin
              inside_braces_next = 1'b1;
            end
            if (outer_last == CH_LF && ch == CH_RBRACE) begin
              inside_braces_next = 1'b0;
            end
            outer_last_next = ch;
          end
        end
      endcase
    end

    // chunk close returns everything but the line counter to reset
    if (done_res) begin
      lex_mode_next      = MODE_NORMAL;
      comment_depth_next = 8'd0;
      quote_kind_next    = 8'd0;
      inner_last_next    = 8'd0;
      outer_last_next    = 8'd0;
      inside_braces_next = 1'b0;
    end

    byte_res = keep_res ? ch : 8'd0;
  end

  // lexer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode      <= MODE_NORMAL;
      comment_depth <= 8'd0;
      quote_kind    <= 8'd0;
      inner_last    <= 8'd0;
      outer_last    <= 8'd0;
      inside_braces <= 1'b0;
    end else if (in_accept) begin
      lex_mode      <= lex_mode_next;
      comment_depth <= comment_depth_next;
      quote_kind    <= quote_kind_next;
      inner_last    <= inner_last_next;
      outer_last    <= outer_last_next;
      inside_braces <= inside_braces_next;
    end
  end

  // line counter, loaded by a config write
  always_ff @(posedge clk) begin
    if (rst) begin
      line_counter <= START_LINE_RST;
    end else if (cfg_wen) begin
      line_counter <= cfg_wdata;
    end else if (in_accept) begin
      line_counter <= line_counter_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      byte_out   <= byte_res;
      keep       <= keep_res;
      chunk_done <= done_res;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.byte_out   = byte_out;
  assign out_ch.keep       = keep;
  assign out_ch.chunk_done = chunk_done;
  assign out_ch.line_now   = line_counter;

endmodule

@@ rtl/core/scs_checker.sv @@
`timescale 1ns / 1ps

module scs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  byte_in,
  input logic        end_of_text,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  byte_out,
  input logic        keep,
  input logic        chunk_done,
  input logic [31:0] line_now
);

  // output register empty right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_out) && $stable(keep)
      && $stable(chunk_done) && $stable(line_now))
    else $error("stalled result changed");

  // end of text closes the chunk and keeps nothing
  a_eot_close: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && end_of_text |=>
      out_valid && chunk_done && !keep && byte_out == 8'd0)
    else $error("end of text did not close the chunk");

  // carriage return is dropped and never closes a chunk
  a_cr_drop: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !end_of_text && byte_in == 8'h0D |=>
      out_valid && !keep && !chunk_done)
    else $error("carriage return not dropped");

endmodule

bind script_chunk_splitter scs_checker u_scs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .byte_in     (in_ch.byte_in),
  .end_of_text (in_ch.end_of_text),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .byte_out    (out_ch.byte_out),
  .keep        (out_ch.keep),
  .chunk_done  (out_ch.chunk_done),
  .line_now    (out_ch.line_now)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import scs_pkg::*;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_text;
  } script_byte_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic        keep;
    logic        chunk_done;
    logic [31:0] line_now;
  } chunk_res_t;

  logic clk;
  logic rst;
  logic cfg_wen;
  logic [31:0] cfg_wdata;

  scs_in_if  in_ch ();
  scs_out_if out_ch ();

  script_chunk_splitter DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  // bytes waiting to be sent, results waiting to arrive
  script_byte_t script_bytes[$];
  chunk_res_t   chunk_results_due[$];
  int unsigned  queued_count;
  int unsigned  err_count;

  // handshake bookkeeping shared by driver, receiver and monitor
  logic        byte_accepted;
  logic        result_taken;
  logic        feed_busy;
  int unsigned feed_gap;
  int unsigned sink_stall;
  logic        no_idle;

  // splitter state as the testbench sees it
  logic [31:0] start_line;
  logic [31:0] line_cnt;
  lex_mode_t   cur_mode;
  logic [7:0]  cmt_depth;
  logic [7:0]  quote_open;
  logic [7:0]  inner_prev;
  logic [7:0]  outer_prev;
  logic        in_braces;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("[script_chunk_splitter] ERROR");
    $finish;
  end

  // everything but the line counter goes back to its reset value
  task automatic clear_chunk();
    cur_mode   = MODE_NORMAL;
    cmt_depth  = '0;
    quote_open = '0;
    inner_prev = '0;
    outer_prev = '0;
    in_braces  = 1'b0;
  endtask

  // expected result of one accepted byte, updating the lexer state
  task automatic split_byte(input logic [7:0] b, input logic eot, output chunk_res_t r);
    r = '0;
    if (eot) begin
      clear_chunk();
      r.chunk_done = 1'b1;
    end else if (b != CH_CR) begin
      r.keep = 1'b1;
      r.byte_out = b;
      if (b == CH_LF) line_cnt = line_cnt + 32'd1;
      case (cur_mode)
        MODE_COMMENT: begin
          if (inner_prev == CH_STAR && b == CH_SLASH) begin
            if (cmt_depth > 8'd0) cmt_depth = cmt_depth - 8'd1;
          end else if (inner_prev == CH_SLASH && b == CH_STAR) begin
            if (cmt_depth < MAX_NEST) cmt_depth = cmt_depth + 8'd1;
          end
          if (cmt_depth == 8'd0) cur_mode = MODE_NORMAL;
          inner_prev = b;
        end
        MODE_QUOTE: begin
          if (b == quote_open && inner_prev != CH_BSLASH) cur_mode = MODE_NORMAL;
          inner_prev = b;
        end
        default: begin
          if (outer_prev == CH_SLASH && b == CH_STAR) begin
            cur_mode = MODE_COMMENT;
            cmt_depth = 8'd1;
            inner_prev = '0;
          end else if (b == CH_SQUOTE || b == CH_DQUOTE || b == CH_BQUOTE) begin
            cur_mode = MODE_QUOTE;
            quote_open = b;
            inner_prev = b;
          end else if (!in_braces && outer_prev == CH_LF && b == CH_LF) begin
            clear_chunk();
            r.chunk_done = 1'b1;
          end else begin
            if (outer_prev == CH_LBRACE) in_braces = 1'b1;
            if (outer_prev == CH_LF && b == CH_RBRACE) in_braces = 1'b0;
            outer_prev = b;
          end
        end
      endcase
    end
    r.line_now = line_cnt;
  endtask

  function automatic int unsigned pick_wait();
    return no_idle ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  // stimulus helpers
  task automatic push_byte(input logic [7:0] b);
    script_bytes.push_back('{byte_in: b, end_of_text: 1'b0});
    queued_count++;
  endtask

  task automatic push_eot();
    script_bytes.push_back('{byte_in: 8'($urandom_range(0, 255)), end_of_text: 1'b1});
    queued_count++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_word();
    int unsigned len;
    len = $urandom_range(1, 6);
    repeat (len) push_byte(8'($urandom_range(8'h61, 8'h7a)));
  endtask

  task automatic push_symbol();
    case ($urandom_range(0, 9))
      0: push_byte(CH_SLASH);
      1: push_byte(CH_STAR);
      2: push_byte(CH_LBRACE);
      3: push_byte(CH_RBRACE);
      4: push_byte(CH_BSLASH);
      5: push_byte(CH_SQUOTE);
      6: push_byte(CH_DQUOTE);
      7: push_byte(CH_BQUOTE);
      8: push_byte(CH_CR);
      default: push_byte(CH_LF);
    endcase
  endtask

  // one piece of script: mostly well-formed constructs, some noise
  task automatic push_script_piece();
    logic [7:0] q;
    int unsigned n;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: push_word();
      6, 7: push_byte(CH_LF);
      8: begin
        push_byte(CH_CR);
        push_byte(CH_LF);
      end
      9: push_text("\n\n");
      10, 11: begin
        push_byte(CH_LBRACE);
        n = $urandom_range(1, 4);
        repeat (n) begin
          push_word();
          if ($urandom_range(0, 2) == 0) push_text("\n\n");
          else push_byte(8'h20);
        end
        push_byte(CH_LF);
        if ($urandom_range(0, 7) != 0) push_byte(CH_RBRACE);
      end
      12, 13: begin
        push_text("/*");
        n = $urandom_range(1, 3);
        repeat (n) begin
          push_word();
          case ($urandom_range(0, 3))
            0: push_text(" /* ");
            1: push_text(" */ ");
            2: push_byte(CH_LF);
            default: push_symbol();
          endcase
        end
        if ($urandom_range(0, 9) != 0) push_text("*/");
      end
      14, 15: begin
        case ($urandom_range(0, 2))
          0: q = CH_SQUOTE;
          1: q = CH_DQUOTE;
          default: q = CH_BQUOTE;
        endcase
        push_byte(q);
        n = $urandom_range(1, 5);
        repeat (n) begin
          case ($urandom_range(0, 4))
            0: begin
              push_byte(CH_BSLASH);
              push_byte(q);
            end
            1: begin
              push_byte(CH_BSLASH);
              push_byte(CH_BSLASH);
            end
            2: push_byte(CH_LF);
            default: push_word();
          endcase
        end
        if ($urandom_range(0, 9) != 0) push_byte(q);
      end
      16: push_byte(8'($urandom_range(0, 255)));
      17: push_eot();
      default: push_symbol();
    endcase
  endtask

  task automatic push_random_script(input int unsigned n);
    int unsigned stop_at;
    stop_at = queued_count + n;
    while (queued_count < stop_at) push_script_piece();
  endtask

  // block has nothing in flight
  task automatic wait_idle();
    while (script_bytes.size() != 0 || feed_busy || chunk_results_due.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_start_line(input logic [31:0] v);
    wait_idle();
    cfg_wdata <= v;
    cfg_wen <= 1'b1;
    @(negedge clk);
    cfg_wen <= 1'b0;
    start_line = v;
    line_cnt = v;
  endtask

  // idle-free stretches for both sides
  always @(posedge clk) begin
    if ($urandom_range(0, 99) == 0) no_idle = !no_idle;
  end

  // driver: one queued byte per transaction, random gap between them
  always @(negedge clk) begin : feed_proc
    script_byte_t item;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (byte_accepted) begin
        byte_accepted = 1'b0;
        feed_busy = 1'b0;
        feed_gap = pick_wait();
      end
      if (!feed_busy) begin
        if (feed_gap > 0) begin
          feed_gap--;
        end else if (script_bytes.size() != 0) begin
          item = script_bytes.pop_front();
          feed_busy = 1'b1;
          in_ch.byte_in <= item.byte_in;
          in_ch.end_of_text <= item.end_of_text;
        end
      end
      in_ch.valid <= feed_busy;
    end
  end

  // receiver stall per result
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (result_taken) begin
        result_taken = 1'b0;
        sink_stall = pick_wait();
      end
      if (sink_stall > 0) begin
        sink_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // monitor: predict on input transaction, compare on output transaction
  always @(posedge clk) begin : check_proc
    chunk_res_t want;
    chunk_res_t got;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        split_byte(in_ch.byte_in, in_ch.end_of_text, want);
        chunk_results_due.push_back(want);
        byte_accepted = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        result_taken = 1'b1;
        got.byte_out = out_ch.byte_out;
        got.keep = out_ch.keep;
        got.chunk_done = out_ch.chunk_done;
        got.line_now = out_ch.line_now;
        if (chunk_results_due.size() == 0) begin
          flag_error($sformatf("unexpected result byte=%h keep=%b done=%b line=%0d",
                               got.byte_out, got.keep, got.chunk_done, got.line_now));
        end else begin
          want = chunk_results_due.pop_front();
          if (got.byte_out !== want.byte_out || got.keep !== want.keep ||
              got.chunk_done !== want.chunk_done || got.line_now !== want.line_now)
            flag_error({
              $sformatf("mismatch at %0t: exp byte=%h keep=%b done=%b line=%0d",
                        $realtime, want.byte_out, want.keep, want.chunk_done,
                        want.line_now),
              $sformatf(", got byte=%h keep=%b done=%b line=%0d",
                        got.byte_out, got.keep, got.chunk_done, got.line_now)});
        end
      end
    end
  end

  // stimulus sequence
  initial begin
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.byte_in = '0;
    in_ch.end_of_text = 1'b0;
    out_ch.ready = 1'b0;
    queued_count = 0;
    err_count = 0;
    byte_accepted = 1'b0;
    result_taken = 1'b0;
    feed_busy = 1'b0;
    feed_gap = 0;
    sink_stall = 0;
    no_idle = 1'b0;
    start_line = START_LINE_RST;
    line_cnt = START_LINE_RST;
    clear_chunk();
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed: byte extremes, dropped cr, blank line, brace block,
    // escaped quote, nested comment, '*' reopening after a comment, end of text
    push_byte(8'h00);
    push_byte(8'hff);
    push_byte(CH_CR);
    push_text("\n\n");
    push_text("{a\n\n}\n\n");
    push_text("'\\''");
    push_text("/*/**/ */*");
    push_eot();

    // line counter wrap
    write_start_line(32'hffff_ffff);
    push_text("\nx\n\n");
    push_random_script(100);

    // start line zero
    write_start_line(32'h0000_0000);
    push_random_script(140);

    // comments nested many levels deep and back out
    write_start_line($urandom());
    push_text("/*");
    repeat (30) push_text(" /*");
    repeat (31) push_text(" */");
    push_text("\n\n");
    push_eot();

    write_start_line(32'd1);
    push_random_script(140);

    wait_idle();
    if (chunk_results_due.size() != 0)
      flag_error($sformatf("%0d results never arrived", chunk_results_due.size()));
    if (err_count == 0) begin
      $display("[script_chunk_splitter] OK");
    end else begin
      $display("[script_chunk_splitter] ERROR");
    end
    $finish;
  end

endmodule
